// ===== hdl/sorted_key_table_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sorted key table RTL.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SKT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SKT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/skt_pkg.sv =====
// ---------------------------------------------------------------------------
// skt_pkg
// Types and codes shared by the sorted key table cells, top level and bench.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package skt_pkg;

    localparam int KEY_W   = 32;
    localparam int VAL_W   = 31;
    localparam int COUNT_W = 11;
    localparam int HIT_W   = VAL_W + 1;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_INSERTED = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_WAIT,
        S_APPLY
    } state_t;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                    cmp_en;
        logic                    ins_en;
        logic                    upd_en;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        value;
    } skt_ctrl_t;

endpackage

// ===== hdl/skt_cell.sv =====
// ---------------------------------------------------------------------------
// skt_cell
// One table slot: holds a key/data pair, compares against the broadcast key
// and takes its lower neighbour's pair when an insert opens a gap below.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_cell
    import skt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 11
) (
    input  logic                    aclk,
    input  skt_ctrl_t               ctrl,
    input  logic [CW-1:0]           count,
    input  logic signed [KEY_W-1:0] prev_key,
    input  logic [VAL_W-1:0]        prev_value,
    input  logic                    prev_lt,
    output logic signed [KEY_W-1:0] key_out,
    output logic [VAL_W-1:0]        value_out,
    output logic                    lt_out,
    output logic [HIT_W-1:0]        hit_out
);

    logic signed [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0]        value_reg;
    logic                    lt_reg;
    logic                    eq_reg;
    logic                    held;

    // slot holds a record when its index is below the count
    assign held = (count > CW'(IDX));

    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            lt_reg <= held && (key_reg < ctrl.key);
            eq_reg <= held && (key_reg == ctrl.key);
        end
        if (ctrl.ins_en && !lt_reg) begin
            if (prev_lt) begin
                key_reg   <= ctrl.key;
                value_reg <= ctrl.value;
            end else begin
                key_reg   <= prev_key;
                value_reg <= prev_value;
            end
        end else if (ctrl.upd_en && eq_reg) begin
            value_reg <= ctrl.value;
        end
    end

    assign key_out   = key_reg;
    assign value_out = value_reg;
    assign lt_out    = lt_reg;
    assign hit_out   = eq_reg ? {1'b1, value_reg} : '0;

endmodule

// ===== hdl/skt_or_tree.sv =====
// ---------------------------------------------------------------------------
// skt_or_tree
// Registered OR reduction, eight inputs per node, each level registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_or_tree #(
    parameter int N = 2,
    parameter int W = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              vld_in,
    input  logic [N-1:0][W-1:0] din,
    output logic              vld_out,
    output logic [W-1:0]      dout
);

    localparam int G  = 8;
    localparam int NG = (N + G - 1) / G;
    localparam int NP = NG * G;

    logic [NP-1:0][W-1:0] pad;
    logic [NG-1:0][W-1:0] grp_reg;
    logic [NG-1:0][W-1:0] grp_next;
    logic                 vld_reg;

    assign pad = (NP * W)'(din);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_next[g] = '0;
            for (int j = 0; j < G; j++) begin
                grp_next[g] = grp_next[g] | pad[g*G + j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_in;
        end
        grp_reg <= grp_next;
    end

    generate
        if (NG == 1) begin : g_root
            assign dout    = grp_reg[0];
            assign vld_out = vld_reg;
        end else begin : g_more
            skt_or_tree #(
                .N (NG),
                .W (W)
            ) u_next (
                .aclk    (aclk),
                .aresetn (aresetn),
                .vld_in  (vld_reg),
                .din     (grp_reg),
                .vld_out (vld_out),
                .dout    (dout)
            );
        end
    endgenerate

endmodule

// ===== hdl/sorted_key_table.sv =====
// ---------------------------------------------------------------------------
// sorted_key_table
// Sorted table of unique signed keys with data, held in a chain of cells.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one request per handshake (op, key, value). Insert
//   overwrites the data of an equal key, otherwise opens a gap above the
//   smaller keys and places the pair there; a new key on a full table is
//   dropped. Lookup reports hit with the data, or miss.
//   Master channel m_*: exactly one result per request (status, value_out,
//   count_out), held in an output register until taken.
// Flow: a request first compares the key in every cell at once. The matching
//   cell's data is collected by the registered eight-way OR tree of depth
//   L = ceil(log2(CAPACITY) / 3) (L = 4 at 1024 entries); the tree result is
//   then held in a register, and the cells are written. A new request is
//   accepted only once the previous one has written the cells.
// Reset: clears the record count to zero and the sequencer to idle; the
//   cell contents are not cleared and are only read below the count.
// Stall: a result waiting on m_tready does not block acceptance of the next
//   request; that request holds in the write step until the output frees.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_key_table_defines.svh"

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // op[0], key[32:1], value[63:33]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[2:0], value_out[33:3], count_out[44:34], zero
);

    localparam int CW = $clog2(CAPACITY + 1);

    state_t                  state_reg, state_next;
    op_t                     req_op_reg;
    logic signed [KEY_W-1:0] req_key_reg;
    logic [VAL_W-1:0]        req_value_reg;
    logic                    tree_start_reg;
    logic                    found_reg;
    logic [VAL_W-1:0]        hit_val_reg;
    logic [CW-1:0]           count_reg, count_next;
    logic                    m_tvalid_reg;
    logic [47:0]             m_tdata_reg;

    logic                    apply;
    logic                    full;
    status_t                 res_status;
    logic [VAL_W-1:0]        res_value;
    skt_ctrl_t               ctrl;

    logic signed [KEY_W-1:0] cell_key   [CAPACITY];
    logic [VAL_W-1:0]        cell_value [CAPACITY];
    logic                    cell_lt    [CAPACITY];
    logic [CAPACITY-1:0][HIT_W-1:0] cell_hit;

    logic                    tree_vld;
    logic [HIT_W-1:0]        tree_dout;

    // -----------------------------------------------------------------------
    // Cell chain: each cell compares against the broadcast key and, on an
    // insert, takes its lower neighbour's pair if the gap lies below it.
    // -----------------------------------------------------------------------
    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            if (i == 0) begin : g_first
                skt_cell #(
                    .IDX (i),
                    .CW  (CW)
                ) u_cell (
                    .aclk       (aclk),
                    .ctrl       (ctrl),
                    .count      (count_reg),
                    .prev_key   ('0),
                    .prev_value ('0),
                    .prev_lt    (1'b1),
                    .key_out    (cell_key[i]),
                    .value_out  (cell_value[i]),
                    .lt_out     (cell_lt[i]),
                    .hit_out    (cell_hit[i])
                );
            end else begin : g_rest
                skt_cell #(
                    .IDX (i),
                    .CW  (CW)
                ) u_cell (
                    .aclk       (aclk),
                    .ctrl       (ctrl),
                    .count      (count_reg),
                    .prev_key   (cell_key[i-1]),
                    .prev_value (cell_value[i-1]),
                    .prev_lt    (cell_lt[i-1]),
                    .key_out    (cell_key[i]),
                    .value_out  (cell_value[i]),
                    .lt_out     (cell_lt[i]),
                    .hit_out    (cell_hit[i])
                );
            end
        end
    endgenerate

    // Collect the single matching cell (keys are unique) through the registered OR tree.
    skt_or_tree #(
        .N (CAPACITY),
        .W (HIT_W)
    ) u_tree (
        .aclk    (aclk),
        .aresetn (aresetn),
        .vld_in  (tree_start_reg),
        .din     (cell_hit),
        .vld_out (tree_vld),
        .dout    (tree_dout)
    );

    // -----------------------------------------------------------------------
    // Result and write decisions
    // -----------------------------------------------------------------------
    assign full = (count_reg == CW'(CAPACITY));

    always_comb begin
        res_value  = '0;
        count_next = count_reg;
        if (req_op_reg == OP_LOOKUP) begin
            if (found_reg) begin
                res_status = ST_HIT;
                res_value  = hit_val_reg;
            end else begin
                res_status = ST_MISS;
            end
        end else if (found_reg) begin
            res_status = ST_UPDATED;
        end else if (!full) begin
            res_status = ST_INSERTED;
            count_next = count_reg + 1'b1;
        end else begin
            res_status = ST_FULL;
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer
    // -----------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        apply        = 1'b0;
        ctrl.cmp_en  = 1'b0;
        ctrl.key     = req_key_reg;
        ctrl.value   = req_value_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                ctrl.cmp_en = 1'b1;
                state_next  = S_WAIT;
            end
            S_WAIT: begin
                if (tree_vld) begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    apply      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        ctrl.ins_en = apply && (req_op_reg == OP_INSERT) && !found_reg && !full;
        ctrl.upd_en = apply && (req_op_reg == OP_INSERT) && found_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            tree_start_reg <= 1'b0;
            count_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tree_start_reg <= (state_reg == S_CMP);
            if (apply) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        // capture the request
        if (s_tvalid && s_tready) begin
            req_op_reg    <= op_t'(s_tdata[0]);
            req_key_reg   <= s_tdata[32:1];
            req_value_reg <= s_tdata[63:33];
        end
        // hold the search result
        if (state_reg == S_WAIT && tree_vld) begin
            found_reg   <= tree_dout[HIT_W-1];
            hit_val_reg <= tree_dout[VAL_W-1:0];
        end
        if (apply) begin
            m_tdata_reg <= {3'b000, COUNT_W'(count_next), res_value, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `SKT_ASSERT_IMP(a_tree_in_wait, aclk, aresetn, tree_vld, state_reg == S_WAIT,
        "tree result outside wait state")
    `SKT_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(CAPACITY),
        "record count above capacity")
    `SKT_ASSERT_NXT(a_insert_count, aclk, aresetn, ctrl.ins_en,
        count_reg == $past(count_reg) + 1'b1, "insert did not advance count")
    `SKT_ASSERT_IMP(a_no_write_busy, aclk, aresetn, apply, !m_tvalid_reg || m_tready,
        "result written over an untaken result")

endmodule

// ===== verif/sorted_key_table_tb.sv =====
// ---------------------------------------------------------------------------
// sorted_key_table_tb
// Self-checking bench for the sorted key table.
// ---------------------------------------------------------------------------
// Drives insert and lookup requests into the slave channel and predicts each
// result with a sorted shadow table kept in the bench. Every result taken from
// the master channel is compared field by field against the oldest prediction.
// The run starts with directed requests on the empty table and the key and
// data extremes. It then mixes random traffic, fills the table to capacity and
// keeps hitting the full table. Both channels throttle at random in the early
// phases and stream freely at the end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_table_tb;
    import skt_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int STALL_LIMIT = 1000;  // cycles with no handshake on either side
    localparam int SETTLE_CYCLES = 20;  // well beyond the request latency

    typedef struct packed {
        status_t            status;
        logic [VAL_W-1:0]   value_out;
        logic [COUNT_W-1:0] count_out;
    } table_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;  // op[0], key[32:1], value[63:33]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;       // status[2:0], value_out[33:3], count_out[44:34], zero

    // Shadow of the table contents, kept sorted by ascending key
    logic signed [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
    logic [VAL_W-1:0]        shadow_values [TABLE_DEPTH];
    int                      shadow_count = 0;

    table_result_t pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int requests_sent = 0;
    int status_seen [5] = '{default: 0};
    int stall_cycles = 0;
    int peak_count = 0;

    table_result_t got_result;
    table_result_t want_result;

    sorted_key_table #(
        .CAPACITY(TABLE_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #1 aclk = ~aclk;

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    // First slot whose key is not below the given key (shadow_count if none).
    function automatic int find_slot(input logic signed [KEY_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = shadow_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_keys[mid] < key) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic bit key_held(input logic signed [KEY_W-1:0] key);
        int slot;
        slot = find_slot(key);
        return (slot < shadow_count) && (shadow_keys[slot] == key);
    endfunction

    // Apply one accepted request to the shadow table and return its result.
    function automatic table_result_t table_access(input op_t op,
                                                   input logic signed [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] value);
        table_result_t res;
        int slot;
        bit found;
        slot = find_slot(key);
        found = (slot < shadow_count) && (shadow_keys[slot] == key);
        res.value_out = '0;
        if (op == OP_LOOKUP) begin
            if (found) begin
                res.status = ST_HIT;
                res.value_out = shadow_values[slot];
            end else begin
                res.status = ST_MISS;
            end
        end else if (found) begin
            shadow_values[slot] = value;
            res.status = ST_UPDATED;
        end else if (shadow_count < TABLE_DEPTH) begin
            // open a gap above the smaller keys
            for (int j = shadow_count; j > slot; j--) begin
                shadow_keys[j] = shadow_keys[j-1];
                shadow_values[j] = shadow_values[j-1];
            end
            shadow_keys[slot] = key;
            shadow_values[slot] = value;
            shadow_count++;
            res.status = ST_INSERTED;
        end else begin
            res.status = ST_FULL;
        end
        res.count_out = COUNT_W'(shadow_count);
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Random content
    // -----------------------------------------------------------------------

    function automatic logic [VAL_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return VAL_W'($urandom);
    endfunction

    function automatic logic signed [KEY_W-1:0] fresh_key();
        logic signed [KEY_W-1:0] key;
        do begin
            key = $urandom;
        end while (key_held(key));
        return key;
    endfunction

    // Mostly held keys and their neighbours, so that hits, updates and
    // near misses around the search boundaries all turn up.
    function automatic logic signed [KEY_W-1:0] pick_key();
        int pick;
        logic signed [KEY_W-1:0] base;
        pick = $urandom_range(0, 9);
        base = (shadow_count > 0) ? shadow_keys[$urandom_range(0, shadow_count - 1)]
                                  : KEY_W'($urandom);
        case (pick)
            0, 1, 2, 3: begin
                return base;
            end
            4: begin
                return base + 1;
            end
            5: begin
                return base - 1;
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: return {1'b1, {(KEY_W-1){1'b0}}};
                    1: return {1'b0, {(KEY_W-1){1'b1}}};
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: begin
                return KEY_W'($urandom);
            end
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Sender
    // -----------------------------------------------------------------------

    // Present one request, hold it until taken, then record its prediction.
    // tvalid stays high on exit so that back-to-back requests need no gap.
    task automatic send_request(input op_t op,
                                input logic signed [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {value, key, op};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(table_access(op, key, value));
        requests_sent++;
        if (shadow_count > peak_count) peak_count = shadow_count;
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic send_random(input int n_requests);
        op_t op;
        for (int i = 0; i < n_requests; i++) begin
            op = ($urandom_range(0, 1) == 1) ? OP_LOOKUP : OP_INSERT;
            send_request(op, pick_key(), random_value());
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    task automatic test_empty_and_extremes();
        send_request(OP_LOOKUP, 32'sd0, '0);                // lookup on empty table
        send_request(OP_INSERT, 32'sd0, '0);
        send_request(OP_INSERT, 32'h7fff_ffff, '1);
        send_request(OP_INSERT, 32'h8000_0000, 31'h5555_5555);
        send_request(OP_INSERT, -32'sd1, 31'h2aaa_aaaa);
        send_request(OP_INSERT, 32'sd1, 31'd1);
        send_request(OP_LOOKUP, 32'h8000_0000, '0);
        send_request(OP_LOOKUP, 32'h7fff_ffff, '0);
        send_request(OP_LOOKUP, -32'sd1, '0);
        send_request(OP_LOOKUP, 32'sd2, '0);                // miss between held keys
        send_request(OP_INSERT, 32'h7fff_ffff, '0);         // update an equal key
        send_request(OP_LOOKUP, 32'h7fff_ffff, '1);         // data ignored on lookup
        send_request(OP_LOOKUP, 32'h7fff_fffe, '0);
        send_request(OP_LOOKUP, 32'h8000_0001, '0);
        send_request(OP_INSERT, 32'h4000_0000, '1);
        send_request(OP_LOOKUP, 32'sd1, '1);
        send_request(OP_INSERT, -32'sd1, '1);
        send_request(OP_LOOKUP, -32'sd1, '0);
        drain_results();
    endtask

    task automatic test_mixed_traffic();
        send_random(200);
        drain_results();
    endtask

    // Mostly new keys until the table holds its full capacity.
    task automatic test_fill_to_capacity();
        while (shadow_count < TABLE_DEPTH) begin
            if ($urandom_range(0, 99) < 15) begin
                send_request(OP_LOOKUP, pick_key(), random_value());
            end else begin
                send_request(OP_INSERT, fresh_key(), random_value());
            end
        end
        drain_results();
    endtask

    // New keys are dropped, equal keys still update, lookups keep working.
    task automatic test_full_table();
        int pick;
        for (int i = 0; i < 100; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                send_request(OP_INSERT, fresh_key(), random_value());
            end else if (pick < 7) begin
                send_request(OP_INSERT, shadow_keys[$urandom_range(0, shadow_count - 1)],
                             random_value());
            end else begin
                send_request(OP_LOOKUP, pick_key(), random_value());
            end
        end
    endtask

    task automatic test_back_to_back();
        send_random(200);
        s_tvalid <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Result checker and receiver throttle
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_result.status = status_t'(m_tdata[2:0]);
            got_result.value_out = m_tdata[33:3];
            got_result.count_out = m_tdata[44:34];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $realtime,
                         got_result);
                error_count++;
            end else begin
                want_result = pending_results.pop_front();
                status_seen[want_result.status]++;
                if (got_result.status !== want_result.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d", $realtime,
                             want_result.status, got_result.status);
                    error_count++;
                end
                if (got_result.value_out !== want_result.value_out) begin
                    $display("%0t: value_out mismatch, expected %h actual %h", $realtime,
                             want_result.value_out, got_result.value_out);
                    error_count++;
                end
                if (got_result.count_out !== want_result.count_out) begin
                    $display("%0t: count_out mismatch, expected %0d actual %0d", $realtime,
                             want_result.count_out, got_result.count_out);
                    error_count++;
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // -----------------------------------------------------------------------
    // Watchdog: end the run if neither channel moves for too long
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("sorted_key_table test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender throttled lightly, receiver heavily
        send_idle_pct = 30;
        recv_idle_pct = 52;
        test_empty_and_extremes();
        test_mixed_traffic();

        // swap the throttles while the table fills
        send_idle_pct = 52;
        recv_idle_pct = 30;
        test_fill_to_capacity();

        // stream with no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_table();
        test_back_to_back();

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d requests: %0d hits, %0d misses, %0d updates, %0d inserts, %0d drops",
                 requests_sent, status_seen[ST_HIT], status_seen[ST_MISS],
                 status_seen[ST_UPDATED], status_seen[ST_INSERTED], status_seen[ST_FULL]);
        $display("Table reached %0d of %0d entries under three throttle mixes",
                 peak_count, TABLE_DEPTH);
        if (error_count == 0) begin
            $display("sorted_key_table test passed");
        end else begin
            $display("sorted_key_table test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/skt_pkg.sv
hdl/skt_cell.sv
hdl/skt_or_tree.sv
hdl/sorted_key_table.sv
verif/sorted_key_table_tb.sv
